>>> hw/rtl/nsm_pkg.sv
// Shared types and constants for the 3x3 neighbor similarity mask unit.
// No dependencies; used by every module of the unit.
package nsm_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int ROW_W     = 12;
    localparam int THR_W     = 18;
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int SQ_W      = 2 * CH_W;
    localparam int NRES      = 4;
    localparam int NLANE     = 8;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam logic [CH_W-1:0] CHAN_MASK = 8'hFF;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [8:0]       window_t;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [WID_W-1:0] width;
        logic [ROW_W-1:0] height;
    } cfg_t;

    // Line memory word: upper row in the high half, middle row in the low half.
    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_word_t;

    // One classified pixel handed from the front end to the mask engine.
    typedef struct packed {
        window_t          window;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic [NRES-1:0]  emit;
    } job_t;

endpackage

>>> hw/rtl/nsm_front.sv
// Front end: frame position, two-row line memory and the 3x3 window.
// Classifies which masks each pixel releases. Depends on nsm_pkg.
module nsm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nsm_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  nsm_pkg::pix_t             pixel_color,
    input  logic                      start_of_frame,
    input  logic                      q_full,
    output logic                      push,
    output nsm_pkg::job_t             job
);

    logic [nsm_pkg::COL_W-1:0] col_reg, col_next;
    logic [nsm_pkg::ROW_W-1:0] row_reg, row_next;
    logic [nsm_pkg::WID_W-1:0] w_eff;
    logic [nsm_pkg::ROW_W-1:0] h_eff;
    logic                      restart;
    logic [nsm_pkg::COL_W-1:0] x;
    logic [nsm_pkg::ROW_W-1:0] y;
    logic [nsm_pkg::WID_W-1:0] x_inc;
    logic [nsm_pkg::ROW_W:0]   y_inc;
    logic                      accept;
    logic                      fire;

    logic                      f_valid_reg, f_valid_next;
    nsm_pkg::pix_t             f_pix_reg;
    logic [nsm_pkg::COL_W-1:0] f_x_reg;
    logic [nsm_pkg::ROW_W-1:0] f_y_reg;
    logic                      f_last_col_reg, f_last_row_reg;

    nsm_pkg::line_word_t       mem [nsm_pkg::MAX_WIDTH];
    nsm_pkg::line_word_t       rd_reg;
    logic                      fwd_hit_reg, fwd_hit_next;
    nsm_pkg::line_word_t       fwd_data_reg;
    nsm_pkg::line_word_t       line;
    nsm_pkg::line_word_t       wr_word;

    nsm_pkg::window_t          win_reg, win_next;
    logic [nsm_pkg::NRES-1:0]  emit;

    // Effective frame size: zero counts as one, width saturates at the memory depth.
    always_comb
    begin
        if (cfg.width == '0)
            w_eff = nsm_pkg::WID_W'(1);
        else if (cfg.width > nsm_pkg::WID_W'(nsm_pkg::MAX_WIDTH))
            w_eff = nsm_pkg::WID_W'(nsm_pkg::MAX_WIDTH);
        else
            w_eff = cfg.width;
        h_eff = (cfg.height == '0) ? nsm_pkg::ROW_W'(1) : cfg.height;
    end

    assign restart = start_of_frame
                  || (nsm_pkg::WID_W'(col_reg) >= w_eff)
                  || (row_reg >= h_eff);
    assign x       = restart ? '0 : col_reg;
    assign y       = restart ? '0 : row_reg;
    assign x_inc   = nsm_pkg::WID_W'(x) + nsm_pkg::WID_W'(1);
    assign y_inc   = (nsm_pkg::ROW_W + 1)'(y) + (nsm_pkg::ROW_W + 1)'(1);

    assign fire     = f_valid_reg && ((emit == '0) || !q_full);
    assign in_ready = !f_valid_reg || fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (x_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (y_inc >= (nsm_pkg::ROW_W + 1)'(h_eff)) ? '0 : y_inc[nsm_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = x_inc[nsm_pkg::COL_W-1:0];
                row_next = y;
            end
        end
    end

    assign f_valid_next = accept ? 1'b1 : (fire ? 1'b0 : f_valid_reg);

    // Same-cycle write to the address being read is caught here.
    assign line         = fwd_hit_reg ? fwd_data_reg : rd_reg;
    assign wr_word      = '{upper: line.middle, middle: f_pix_reg};
    assign fwd_hit_next = fire && (f_x_reg == x);

    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = line.upper;
        win_next[5] = line.middle;
        win_next[8] = f_pix_reg;
    end

    always_comb
    begin
        emit[0] = (f_x_reg != '0) && (f_y_reg != '0);
        emit[1] = f_last_col_reg && (f_y_reg != '0);
        emit[2] = f_last_row_reg && (f_x_reg != '0);
        emit[3] = f_last_row_reg && f_last_col_reg;
    end

    assign push = fire && (emit != '0);
    assign job  = '{window: win_next, x: f_x_reg, y: f_y_reg, emit: emit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            f_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            f_valid_reg <= f_valid_next;
            if (accept)
                fwd_hit_reg <= fwd_hit_next;
            if (fire)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_pix_reg      <= pixel_color;
            f_x_reg        <= x;
            f_y_reg        <= y;
            f_last_col_reg <= (nsm_pkg::WID_W'(x) == (w_eff - nsm_pkg::WID_W'(1)));
            f_last_row_reg <= (y == (h_eff - nsm_pkg::ROW_W'(1)));
            fwd_data_reg   <= wr_word;
        end
    end

    // Line memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (fire)
            mem[f_x_reg] <= wr_word;
        if (accept)
            rd_reg <= mem[x];
    end

endmodule

>>> hw/rtl/nsm_queue.sv
// Short job queue between the front end and the mask engine.
// Depends on nsm_pkg.
module nsm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nsm_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output nsm_pkg::job_t head_job
);

    nsm_pkg::job_t              slot_reg [nsm_pkg::QDEPTH];
    logic [nsm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [nsm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [nsm_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_pop;

    assign full       = (count_reg == nsm_pkg::QCNT_W'(nsm_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == nsm_pkg::QPTR_W'(nsm_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + nsm_pkg::QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == nsm_pkg::QPTR_W'(nsm_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + nsm_pkg::QPTR_W'(1);
        if (push && !do_pop)
            count_next = count_reg + nsm_pkg::QCNT_W'(1);
        else if (do_pop && !push)
            count_next = count_reg - nsm_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> hw/rtl/nsm_back.sv
// Mask engine: one mask per cycle from queued windows unless the output stalls; a squaring
// stage, then the distance compare into the output register. Depends on nsm_pkg.
module nsm_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [nsm_pkg::THR_W-1:0]        threshold,
    input  logic                             head_valid,
    input  nsm_pkg::job_t                    head_job,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nsm_pkg::NLANE-1:0]        sim_mask,
    output logic [nsm_pkg::COL_W-1:0]        center_x,
    output logic [nsm_pkg::ROW_W-1:0]        center_y,
    output logic                             last_in_run,
    output logic                             end_of_frame
);

    // Mask kinds in emission order.
    localparam int RES_PREV_ROW      = 0;
    localparam int RES_PREV_ROW_EDGE = 1;
    localparam int RES_LAST_ROW      = 2;
    localparam int RES_CORNER        = 3;

    localparam logic [3:0] CIDX [nsm_pkg::NRES] = '{4'd4, 4'd5, 4'd7, 4'd8};
    // Window cell per lane; lanes that fall outside the window read cell 0 and are masked off.
    localparam logic [3:0] NBR [nsm_pkg::NRES][nsm_pkg::NLANE] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8},
        '{4'd1, 4'd2, 4'd0, 4'd4, 4'd0, 4'd7, 4'd8, 4'd0},
        '{4'd3, 4'd4, 4'd5, 4'd6, 4'd8, 4'd0, 4'd0, 4'd0},
        '{4'd4, 4'd5, 4'd0, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    typedef logic [nsm_pkg::SQ_W-1:0] sq_t;

    logic [nsm_pkg::NRES-1:0]  done_reg, done_next;
    logic [nsm_pkg::NRES-1:0]  pending, sel, rest;
    logic                      s1_adv, out_load, last;

    nsm_pkg::pix_t             center;
    nsm_pkg::pix_t             nb [nsm_pkg::NLANE];
    logic                      up, down, left, right;
    logic [nsm_pkg::NLANE-1:0] lane_en;
    logic [nsm_pkg::COL_W-1:0] cx;
    logic [nsm_pkg::ROW_W-1:0] cy;
    sq_t                       sq [nsm_pkg::NLANE][3];

    logic                      s1_valid_reg, s1_valid_next;
    sq_t                       s1_sq_reg [nsm_pkg::NLANE][3];
    logic [nsm_pkg::NLANE-1:0] s1_en_reg;
    logic [nsm_pkg::COL_W-1:0] s1_cx_reg;
    logic [nsm_pkg::ROW_W-1:0] s1_cy_reg;
    logic                      s1_last_reg, s1_eof_reg;

    logic [nsm_pkg::NLANE-1:0] mask;
    logic                      o_valid_reg, o_valid_next;
    logic [nsm_pkg::NLANE-1:0] o_mask_reg;
    logic [nsm_pkg::COL_W-1:0] o_cx_reg;
    logic [nsm_pkg::ROW_W-1:0] o_cy_reg;
    logic                      o_last_reg, o_eof_reg;

    assign out_load = !o_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || out_load;

    // Lowest pending mask of the head job goes next.
    assign pending = head_job.emit & ~done_reg;
    assign sel     = pending & (~pending + nsm_pkg::NRES'(1));
    assign rest    = pending & ~sel;
    assign last    = (rest == '0);
    assign pop     = s1_adv && head_valid && last;

    always_comb
    begin
        done_next = done_reg;
        if (s1_adv && head_valid)
            done_next = last ? '0 : (done_reg | sel);
    end

    always_comb
    begin
        logic x_ge1, x_ge2, y_ge1, y_ge2;
        x_ge1  = (head_job.x >= nsm_pkg::COL_W'(1));
        x_ge2  = (head_job.x >= nsm_pkg::COL_W'(2));
        y_ge1  = (head_job.y >= nsm_pkg::ROW_W'(1));
        y_ge2  = (head_job.y >= nsm_pkg::ROW_W'(2));
        center = '0;
        for (int k = 0; k < nsm_pkg::NLANE; k++)
            nb[k] = '0;
        for (int r = 0; r < nsm_pkg::NRES; r++)
        begin
            if (sel[r])
            begin
                center = head_job.window[CIDX[r]];
                for (int k = 0; k < nsm_pkg::NLANE; k++)
                    nb[k] = head_job.window[NBR[r][k]];
            end
        end
        if (sel[RES_PREV_ROW] || sel[RES_PREV_ROW_EDGE])
        begin
            up   = y_ge2;
            down = 1'b1;
            cy   = head_job.y - nsm_pkg::ROW_W'(1);
        end
        else
        begin
            up   = y_ge1;
            down = 1'b0;
            cy   = head_job.y;
        end
        if (sel[RES_PREV_ROW] || sel[RES_LAST_ROW])
        begin
            left  = x_ge2;
            right = 1'b1;
            cx    = head_job.x - nsm_pkg::COL_W'(1);
        end
        else
        begin
            left  = x_ge1;
            right = 1'b0;
            cx    = head_job.x;
        end
        lane_en[0] = up && left;
        lane_en[1] = up;
        lane_en[2] = up && right;
        lane_en[3] = left;
        lane_en[4] = right;
        lane_en[5] = down && left;
        lane_en[6] = down;
        lane_en[7] = down && right;
    end

    // Squared channel differences, one small multiplier per lane and channel.
    always_comb
    begin
        logic [nsm_pkg::CH_W-1:0] a, b, d;
        for (int k = 0; k < nsm_pkg::NLANE; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a = center[c*nsm_pkg::CH_W +: nsm_pkg::CH_W] & nsm_pkg::CHAN_MASK;
                b = nb[k][c*nsm_pkg::CH_W +: nsm_pkg::CH_W] & nsm_pkg::CHAN_MASK;
                d = (a > b) ? (a - b) : (b - a);
                sq[k][c] = sq_t'(d) * sq_t'(d);
            end
        end
    end

    // Distance sum and threshold compare.
    always_comb
    begin
        logic [nsm_pkg::THR_W-1:0] dsum;
        for (int k = 0; k < nsm_pkg::NLANE; k++)
        begin
            dsum = nsm_pkg::THR_W'(s1_sq_reg[k][0]) + nsm_pkg::THR_W'(s1_sq_reg[k][1])
                 + nsm_pkg::THR_W'(s1_sq_reg[k][2]);
            mask[k] = s1_en_reg[k] && (dsum < threshold);
        end
    end

    assign s1_valid_next = s1_adv ? head_valid : s1_valid_reg;
    assign o_valid_next  = out_load ? s1_valid_reg : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            done_reg     <= done_next;
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_sq_reg   <= sq;
            s1_en_reg   <= lane_en;
            s1_cx_reg   <= cx;
            s1_cy_reg   <= cy;
            s1_last_reg <= last;
            s1_eof_reg  <= sel[RES_CORNER];
        end
        if (out_load)
        begin
            o_mask_reg <= mask;
            o_cx_reg   <= s1_cx_reg;
            o_cy_reg   <= s1_cy_reg;
            o_last_reg <= s1_last_reg;
            o_eof_reg  <= s1_eof_reg;
        end
    end

    assign out_valid     = o_valid_reg;
    assign sim_mask      = o_mask_reg;
    assign center_x      = o_cx_reg;
    assign center_y      = o_cy_reg;
    assign last_in_run   = o_last_reg;
    assign end_of_frame  = o_eof_reg;

endmodule

>>> hw/rtl/neighbor_similarity_mask_3x3_unit.sv
// Top level of the 3x3 neighbor similarity mask unit: config registers and wiring.
// Depends on nsm_pkg, nsm_front, nsm_queue, nsm_back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: pixel_color; tuser: start_of_frame
//  m_*      | out       | m_tvalid/m_tready  | tdata: mask, center_x, center_y; tlast; tuser
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Cycles: one pixel per clock while each pixel releases at most one mask and m_tready is
//   high; the single mask engine emits one mask per clock while its output is not stalled.
// Path: front-end register, job queue, squaring stage, then the output register.
// Reset: control regs clear, config regs load defaults at once; line memory is not cleared.
// Stalls: a two-entry job queue and the output register let either side stall alone;
//   s_tready does not depend on m_tready combinationally.
module neighbor_similarity_mask_3x3_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] pixel_color
    input  logic        s_tuser,    // [0] start_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] sim_mask, [17:8] center_x, [29:18] center_y
    output logic        m_tlast,    // last_in_run
    output logic        m_tuser,    // [0] end_of_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    nsm_pkg::cfg_t                     cfg_reg, cfg_next;
    logic                              q_full, push, pop, head_valid;
    nsm_pkg::job_t                     push_job, head_job;
    logic [nsm_pkg::NLANE-1:0]         sim_mask;
    logic [nsm_pkg::COL_W-1:0]         center_x;
    logic [nsm_pkg::ROW_W-1:0]         center_y;

    // Config writes are always accepted and registered.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (nsm_pkg::cfg_idx_t'(cfg_index))
                nsm_pkg::CFG_THRESHOLD: cfg_next.threshold = cfg_data;
                nsm_pkg::CFG_WIDTH:     cfg_next.width     = cfg_data[nsm_pkg::WID_W-1:0];
                nsm_pkg::CFG_HEIGHT:    cfg_next.height    = cfg_data[nsm_pkg::ROW_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= nsm_pkg::THR_W'(2500);
            cfg_reg.width     <= nsm_pkg::WID_W'(640);
            cfg_reg.height    <= nsm_pkg::ROW_W'(480);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: position tracking, line memory, window, classification.
    nsm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .pixel_color    (s_tdata),
        .start_of_frame (s_tuser),
        .q_full         (q_full),
        .push           (push),
        .job            (push_job)
    );

    nsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back end: one mask per clock unless the output stalls, registered output.
    nsm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .threshold     (cfg_reg.threshold),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .sim_mask      (sim_mask),
        .center_x      (center_x),
        .center_y      (center_y),
        .last_in_run   (m_tlast),
        .end_of_frame  (m_tuser)
    );

    assign m_tdata = {2'b00, center_y, center_x, sim_mask};

endmodule

>>> hw/rtl/nsm_checker.sv
// Port-level checks for the 3x3 neighbor similarity mask unit, bound to the top level.
// Depends only on the top level's ports.
module nsm_props (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // The bottom-right mask is always the final one of its pixel.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame without last");

    // Bottom-right pixel has no right or lower neighbors.
    a_eof_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[7:0] & 8'hF4) == 8'h00)
        else $error("end of frame mask has outside neighbors");

    // Top row and left column centers have no upper or left neighbors.
    a_edge_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[29:18] != 12'd0) || (m_tdata[2:0] == 3'd0))
                     && ((m_tdata[17:8] != 10'd0) || ((m_tdata[7:0] & 8'h29) == 8'h00)))
        else $error("edge mask has outside neighbors");

endmodule

bind neighbor_similarity_mask_3x3_unit nsm_props u_nsm_props (.*);
